@@ hw/rtl/vau_pkg.sv @@
// ----------------------------------------------------------------------------
// vau_pkg
// Types, operation codes and shared helpers of the vector arithmetic unit.
// ----------------------------------------------------------------------------
package vau_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   typedef logic signed [31:0] fix_type;

   typedef enum logic [3:0] {
      OP_ADD       = 4'd0,
      OP_SUB       = 4'd1,
      OP_NEGATE    = 4'd2,
      OP_SCALE     = 4'd3,
      OP_LENGTH    = 4'd4,
      OP_NORMALIZE = 4'd5,
      OP_DISTANCE  = 4'd6,
      OP_DOT       = 4'd7,
      OP_CROSS     = 4'd8
   } op_type;

   typedef struct packed {
      logic [3:0] req_type;
      fix_type    a_x;
      fix_type    a_y;
      fix_type    a_z;
      fix_type    b_x;
      fix_type    b_y;
      fix_type    b_z;
      fix_type    scale_factor;
   } request_type;

   typedef struct packed {
      fix_type r_x;
      fix_type r_y;
      fix_type r_z;
      fix_type scalar_out;
      logic    overflow;
   } response_type;

   // Item as classified by the front end. For add, subtract, negate and
   // distance the a vector already holds the saturated componentwise result.
   typedef struct packed {
      op_type           op;
      logic [2:0][31:0] a;
      logic [2:0][31:0] b;
      logic [31:0]      s;
      logic             ov;
   } work_type;

   // Sideband that travels with an item through the back end.
   typedef struct packed {
      op_type           op;
      logic [2:0][31:0] a;
      logic [2:0][31:0] r;
      logic [31:0]      sc;
      logic [31:0]      len;
      logic             ov;
   } side_type;

   typedef struct packed {
      logic        ov;
      logic [31:0] value;
   } sat_type;

   // Clamps a wide signed value to the 32-bit range.
   function automatic sat_type sat_fix(input logic signed [65:0] v);
      sat_type res;
      res.ov    = !((v[65:31] == '0) || (v[65:31] == '1));
      res.value = v[31:0];
      if (res.ov) begin
         res.value = v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/vau_fifo.sv @@
// ----------------------------------------------------------------------------
// vau_fifo
// Small register-based queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module vau_fifo #(
   parameter type data_type = logic,
   parameter int  DEPTH     = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  data_type push_data,
   output logic     full,
   input  logic     pop,
   output data_type pop_data,
   output logic     empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   data_type        store_ff [0:DEPTH-1];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_cnt_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not follow a lone transfer in");

endmodule

@@ hw/rtl/vau_front.sv @@
// ----------------------------------------------------------------------------
// vau_front
// Front end: takes requests, decodes the operation and resolves the
// componentwise add, subtract, negate and distance differences.
// ----------------------------------------------------------------------------
module vau_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  vau_pkg::request_type req_data,
   output logic                 req_full,
   output logic                 work_push,
   output vau_pkg::work_type    work_data,
   input  logic                 work_full
);
   import vau_pkg::*;

   logic             valid_ff, valid_in;
   work_type         work_ff, work_in;
   logic             advance;
   logic             accept;
   logic [2:0][31:0] va, vb;
   logic signed [65:0] x, y, sum;
   sat_type          sat;

   assign advance   = !valid_ff || !work_full;
   assign req_full  = !advance;
   assign accept    = req_push && advance;
   assign work_push = valid_ff && !work_full;
   assign work_data = work_ff;

   always_comb begin
      va = {req_data.a_z, req_data.a_y, req_data.a_x};
      vb = {req_data.b_z, req_data.b_y, req_data.b_x};
      work_in.op = op_type'(req_data.req_type);
      work_in.a  = va;
      work_in.b  = vb;
      work_in.s  = req_data.scale_factor;
      work_in.ov = 1'b0;
      for (int i = 0; i < 3; i++) begin
         x   = (work_in.op == OP_NEGATE) ? 66'sd0 : 66'($signed(va[i]));
         y   = (work_in.op == OP_NEGATE) ? 66'($signed(va[i])) : 66'($signed(vb[i]));
         sum = (work_in.op == OP_ADD) ? x + y : x - y;
         sat = sat_fix(sum);
         if (work_in.op inside {OP_ADD, OP_SUB, OP_NEGATE, OP_DISTANCE}) begin
            work_in.a[i] = sat.value;
            work_in.ov   = work_in.ov | sat.ov;
         end
      end
      valid_in = accept ? 1'b1 : (work_push ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         work_ff <= work_in;
      end
   end

endmodule

@@ hw/rtl/vau_sqrt.sv @@
// ----------------------------------------------------------------------------
// vau_sqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module vau_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [63:0]       in_n,
   input  vau_pkg::side_type in_side,
   output logic              out_valid,
   output logic [31:0]       out_root,
   output vau_pkg::side_type out_side
);
   import vau_pkg::*;

   localparam int STAGES = 32;

   logic        v_ff    [0:STAGES-1];
   logic [35:0] rem_ff  [0:STAGES-1];
   logic [31:0] root_ff [0:STAGES-1];
   logic [63:0] n_ff    [0:STAGES-1];
   side_type    side_ff [0:STAGES-1];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic        pv;
      logic [35:0] prem, rem_sh, trial, rem_in;
      logic [31:0] proot;
      logic [63:0] pn;
      side_type    pside;
      logic        ge;

      if (s == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = '0;
         assign proot = '0;
         assign pn    = in_n;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[s-1];
         assign prem  = rem_ff[s-1];
         assign proot = root_ff[s-1];
         assign pn    = n_ff[s-1];
         assign pside = side_ff[s-1];
      end

      // Bring down the next two radicand bits and try 4*root+1.
      always_comb begin
         rem_sh = {prem[33:0], pn[2*(STAGES-1-s)+1 -: 2]};
         trial  = {2'b00, proot, 2'b01};
         ge     = (rem_sh >= trial);
         rem_in = ge ? rem_sh - trial : rem_sh;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= {proot[30:0], ge};
            n_ff[s]    <= pn;
            side_ff[s] <= pside;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

@@ hw/rtl/vau_div.sv @@
// ----------------------------------------------------------------------------
// vau_div
// Pipelined restoring divider for normalize: each component scaled by
// 2^FRAC_BITS over the length, truncated toward zero, three lanes.
// ----------------------------------------------------------------------------
module vau_div #(
   parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  vau_pkg::side_type in_side,
   output logic              out_valid,
   output logic [2:0][31:0]  out_quo,
   output vau_pkg::side_type out_side
);
   import vau_pkg::*;

   localparam int STAGES = FRAC_BITS + 1;
   localparam int DW     = FRAC_BITS + 33;
   localparam int QW     = FRAC_BITS + 1;

   logic                   v_ff    [0:STAGES-1];
   logic [2:0][DW-1:0]     rem_ff  [0:STAGES-1];
   logic [2:0][QW-1:0]     q_ff    [0:STAGES-1];
   side_type               side_ff [0:STAGES-1];
   logic [2:0][DW-1:0]     num;

   // The magnitude never exceeds the length, so the quotient fits QW bits.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num[k] = DW'(in_side.a[k][31] ? 32'(-in_side.a[k]) : in_side.a[k]) << FRAC_BITS;
      end
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic               pv;
      logic [2:0][DW-1:0] prem, rem_in;
      logic [2:0][QW-1:0] pq, q_in;
      side_type           pside;
      logic [DW-1:0]      divisor;

      if (s == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = num;
         assign pq    = '0;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[s-1];
         assign prem  = rem_ff[s-1];
         assign pq    = q_ff[s-1];
         assign pside = side_ff[s-1];
      end

      always_comb begin
         divisor = DW'(pside.len) << (FRAC_BITS - s);
         for (int k = 0; k < 3; k++) begin
            if (prem[k] >= divisor) begin
               rem_in[k] = prem[k] - divisor;
               q_in[k]   = pq[k] | (QW'(1) << (FRAC_BITS - s));
            end else begin
               rem_in[k] = prem[k];
               q_in[k]   = pq[k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in;
            q_ff[s]    <= q_in;
            side_ff[s] <= pside;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         out_quo[k] = out_side.a[k][31] ? -(32'(q_ff[STAGES-1][k]))
                                        : 32'(q_ff[STAGES-1][k]);
      end
   end

endmodule

@@ hw/rtl/vau_back.sv @@
// ----------------------------------------------------------------------------
// vau_back
// Back end: multiplier stage, product reduction and saturation, square root
// and divider pipelines, and result formatting. The whole pipeline moves
// together and holds while the result queue is full.
// ----------------------------------------------------------------------------
module vau_back #(
   parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  work_empty,
   input  vau_pkg::work_type     work_data,
   output logic                  work_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output vau_pkg::response_type rsp_data
);
   import vau_pkg::*;

   logic                      adv;
   logic                      take;

   // Multiplier stage.
   logic                      m1_v_ff;
   logic signed [63:0]        m1_p_ff [0:5];
   logic signed [63:0]        p_in    [0:5];
   side_type                  m1_side_ff, m1_side_in;
   logic [2:0][31:0]          mx, my;

   // Reduction stage.
   logic                      m2_v_ff;
   logic [63:0]               m2_n_ff, m2_n_in;
   side_type                  m2_side_ff, m2_side_in;
   logic signed [63:0]        fs [0:5];
   sat_type                   sat_r [0:2];
   sat_type                   sat_d;

   logic                      sq_v;
   logic [31:0]               sq_root;
   side_type                  sq_side, dv_in_side;
   logic                      dv_v;
   logic [2:0][31:0]          dv_quo;
   side_type                  dv_side;

   assign adv      = !rsp_full;
   assign take     = adv && !work_empty;
   assign work_pop = take;

   // Operand selection for the six multipliers. Lanes 0 to 2 carry scale, dot,
   // squares and the first cross terms; lanes 3 to 5 the subtracted cross terms.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mx[i] = work_data.a[i];
         my[i] = work_data.a[i];
      end
      case (work_data.op)
         OP_SCALE: begin
            my = {work_data.s, work_data.s, work_data.s};
         end
         OP_DOT: begin
            my = work_data.b;
         end
         OP_CROSS: begin
            mx = {work_data.a[0], work_data.a[2], work_data.a[1]};
            my = {work_data.b[1], work_data.b[0], work_data.b[2]};
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         p_in[i] = $signed(mx[i]) * $signed(my[i]);
      end
      p_in[3] = $signed(work_data.a[2]) * $signed(work_data.b[1]);
      p_in[4] = $signed(work_data.a[0]) * $signed(work_data.b[2]);
      p_in[5] = $signed(work_data.a[1]) * $signed(work_data.b[0]);

      m1_side_in    = '0;
      m1_side_in.op = work_data.op;
      m1_side_in.a  = work_data.a;
      m1_side_in.ov = work_data.ov;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
      end else if (adv) begin
         m1_v_ff <= take;
         m2_v_ff <= m1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 6; i++) begin
            m1_p_ff[i] <= p_in[i];
         end
         m1_side_ff <= m1_side_in;
         m2_n_ff    <= m2_n_in;
         m2_side_ff <= m2_side_in;
      end
   end

   // Products are floored by the arithmetic shift before the dot and cross sums; the length sum uses the raw products.
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         fs[i] = m1_p_ff[i] >>> FRAC_BITS;
      end
      m2_n_in    = 64'(m1_p_ff[0]) + 64'(m1_p_ff[1]) + 64'(m1_p_ff[2]);
      m2_side_in = m1_side_ff;
      for (int i = 0; i < 3; i++) begin
         sat_r[i] = sat_fix((m1_side_ff.op == OP_CROSS) ? 66'(fs[i]) - 66'(fs[i+3])
                                                       : 66'(fs[i]));
      end
      sat_d = sat_fix(66'(fs[0]) + 66'(fs[1]) + 66'(fs[2]));
      case (m1_side_ff.op)
         OP_ADD, OP_SUB, OP_NEGATE: begin
            m2_side_in.r = m1_side_ff.a;
         end
         OP_SCALE, OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               m2_side_in.r[i] = sat_r[i].value;
            end
            m2_side_in.ov = sat_r[0].ov | sat_r[1].ov | sat_r[2].ov;
         end
         OP_DOT: begin
            m2_side_in.sc = sat_d.value;
            m2_side_in.ov = sat_d.ov;
         end
         OP_LENGTH, OP_NORMALIZE, OP_DISTANCE: begin
         end
         default: begin
            m2_side_in.ov = 1'b0;
         end
      endcase
   end

   vau_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (m2_v_ff),
      .in_n      (m2_n_ff),
      .in_side   (m2_side_ff),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      dv_in_side     = sq_side;
      dv_in_side.len = sq_root;
   end

   vau_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_v),
      .in_side   (dv_in_side),
      .out_valid (dv_v),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   assign rsp_push = dv_v && adv;

   always_comb begin
      rsp_data            = '0;
      rsp_data.r_x        = dv_side.r[0];
      rsp_data.r_y        = dv_side.r[1];
      rsp_data.r_z        = dv_side.r[2];
      rsp_data.scalar_out = dv_side.sc;
      rsp_data.overflow   = dv_side.ov;
      case (dv_side.op)
         OP_LENGTH, OP_DISTANCE: begin
            rsp_data.scalar_out = dv_side.len[31] ? 32'h7FFF_FFFF : dv_side.len;
            rsp_data.overflow   = dv_side.ov | dv_side.len[31];
         end
         OP_NORMALIZE: begin
            // A zero-length vector normalizes to the zero vector.
            if (dv_side.len != '0) begin
               rsp_data.r_x = dv_quo[0];
               rsp_data.r_y = dv_quo[1];
               rsp_data.r_z = dv_quo[2];
            end
         end
         default: begin
         end
      endcase
   end

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!adv && dv_v) |=> dv_v)
      else $error("result left the pipeline while the result queue was full");

endmodule

@@ hw/rtl/vector3_arithmetic_unit.sv @@
// Path: a request is registered in the front end, then passes the work queue,
//   the multiplier, reduction, square root and divider stages and the result queue.
// Throughput: one request per cycle for every operation while the result queue is
//   not full; the 32-stage square root and the FRAC_BITS + 1 stage divider are fully pipelined.
// Reset: synchronous, active high; empties both queues and all stage valids.
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// Three-component Q fixed-point vector unit: add, subtract, negate, scale,
// length, normalize, distance, dot and cross with saturation.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit #(
   parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  vau_pkg::request_type  req_data,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output vau_pkg::response_type rsp_data
);
   import vau_pkg::*;

   localparam int WORK_DEPTH = 4;
   localparam int RSP_DEPTH  = 2;

   logic         work_push, work_full, work_pop, work_empty;
   work_type     work_in_data, work_out_data;
   logic         res_push, res_full;
   response_type res_data;

   vau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .work_push (work_push),
      .work_data (work_in_data),
      .work_full (work_full)
   );

   vau_fifo #(
      .data_type (work_type),
      .DEPTH     (WORK_DEPTH)
   ) u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_in_data),
      .full      (work_full),
      .pop       (work_pop),
      .pop_data  (work_out_data),
      .empty     (work_empty)
   );

   vau_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_empty (work_empty),
      .work_data  (work_out_data),
      .work_pop   (work_pop),
      .rsp_full   (res_full),
      .rsp_push   (res_push),
      .rsp_data   (res_data)
   );

   vau_fifo #(
      .data_type (response_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

@@ bench/tb_vector3_arithmetic_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector3_arithmetic_unit
// Drives operation requests into the vector unit through its request side and
// checks every response against a listed result or a fixed-point predictor of the operations.
// ----------------------------------------------------------------------------
module tb_vector3_arithmetic_unit;
   import vau_pkg::*;

   localparam int FB        = FRAC_BITS_DEFAULT;
   localparam int LATENCY   = FB + 37;
   localparam int N_RANDOM  = 450;
   localparam int WATCHDOG  = 20000;
   localparam logic signed [31:0] FIX_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] FIX_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE     = 32'sh0001_0000;

   logic clock;
   logic reset;
   logic req_push;
   request_type req_data;
   logic req_full;
   logic rsp_empty;
   logic rsp_pop;
   response_type rsp_data;

   response_type expected_q[$];
   int errors;
   int idle_cycles;
   bit stim_done;
   bit hold_rsp;

   typedef struct {
      request_type  req;
      bit           known;
      response_type rsp;
   } stim_row;

   vector3_arithmetic_unit #(.FRAC_BITS(FB)) u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor of a wide product shifted down by the fraction bits.
   function automatic logic signed [95:0] fix_mul(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
      logic signed [95:0] p;
      p = 96'(x) * 96'(y);
      return p >>> FB;
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [95:0] v,
                                                  inout bit ov);
      if (v > 96'(FIX_MAX)) begin
         ov = 1'b1;
         return FIX_MAX;
      end
      if (v < 96'(FIX_MIN)) begin
         ov = 1'b1;
         return FIX_MIN;
      end
      return v[31:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [65:0] n);
      logic [65:0] root;
      logic [65:0] bitv;
      root = '0;
      bitv = 66'd1 << 64;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[63:0];
   endfunction

   function automatic logic [63:0] vec_length(input logic signed [31:0] x,
                                              input logic signed [31:0] y,
                                              input logic signed [31:0] z);
      logic [65:0] sum;
      sum = 66'(64'(x * 64'sd1) * 64'(x * 64'sd1))
          + 66'(64'(y * 64'sd1) * 64'(y * 64'sd1))
          + 66'(64'(z * 64'sd1) * 64'(z * 64'sd1));
      return floor_sqrt(sum);
   endfunction

   function automatic logic signed [31:0] clamp_len(input logic [63:0] l, inout bit ov);
      if (l > 64'(FIX_MAX)) begin
         ov = 1'b1;
         return FIX_MAX;
      end
      return l[31:0];
   endfunction

   function automatic response_type predict_vector_op(input request_type q);
      response_type res;
      logic signed [31:0] a[3];
      logic signed [31:0] b[3];
      logic signed [31:0] d[3];
      logic signed [95:0] num;
      logic [63:0] len;
      bit ov;
      res = '0;
      ov  = 1'b0;
      a = '{q.a_x, q.a_y, q.a_z};
      b = '{q.b_x, q.b_y, q.b_z};
      case (q.req_type)
         OP_ADD: begin
            res.r_x = clamp32(96'(a[0]) + 96'(b[0]), ov);
            res.r_y = clamp32(96'(a[1]) + 96'(b[1]), ov);
            res.r_z = clamp32(96'(a[2]) + 96'(b[2]), ov);
         end
         OP_SUB: begin
            res.r_x = clamp32(96'(a[0]) - 96'(b[0]), ov);
            res.r_y = clamp32(96'(a[1]) - 96'(b[1]), ov);
            res.r_z = clamp32(96'(a[2]) - 96'(b[2]), ov);
         end
         OP_NEGATE: begin
            res.r_x = clamp32(-96'(a[0]), ov);
            res.r_y = clamp32(-96'(a[1]), ov);
            res.r_z = clamp32(-96'(a[2]), ov);
         end
         OP_SCALE: begin
            res.r_x = clamp32(fix_mul(a[0], q.scale_factor), ov);
            res.r_y = clamp32(fix_mul(a[1], q.scale_factor), ov);
            res.r_z = clamp32(fix_mul(a[2], q.scale_factor), ov);
         end
         OP_LENGTH: res.scalar_out = clamp_len(vec_length(a[0], a[1], a[2]), ov);
         OP_NORMALIZE: begin
            len = vec_length(a[0], a[1], a[2]);
            if (len != 0) begin
               num = 96'(a[0]) <<< FB;
               res.r_x = 32'(num / $signed({32'd0, len}));
               num = 96'(a[1]) <<< FB;
               res.r_y = 32'(num / $signed({32'd0, len}));
               num = 96'(a[2]) <<< FB;
               res.r_z = 32'(num / $signed({32'd0, len}));
            end
         end
         OP_DISTANCE: begin
            for (int i = 0; i < 3; i++) d[i] = clamp32(96'(a[i]) - 96'(b[i]), ov);
            res.scalar_out = clamp_len(vec_length(d[0], d[1], d[2]), ov);
         end
         OP_DOT:
            res.scalar_out = clamp32(fix_mul(a[0], b[0]) + fix_mul(a[1], b[1])
                                     + fix_mul(a[2], b[2]), ov);
         OP_CROSS: begin
            res.r_x = clamp32(fix_mul(a[1], b[2]) - fix_mul(a[2], b[1]), ov);
            res.r_y = clamp32(fix_mul(a[2], b[0]) - fix_mul(a[0], b[2]), ov);
            res.r_z = clamp32(fix_mul(a[0], b[1]) - fix_mul(a[1], b[0]), ov);
         end
         default: ;
      endcase
      res.overflow = ov;
      return res;
   endfunction

   function automatic request_type make_req(input logic [3:0] op,
                                            input logic signed [31:0] ax, ay, az,
                                            input logic signed [31:0] bx, by, bz,
                                            input logic signed [31:0] s);
      request_type q;
      q.req_type = op;
      q.a_x = ax; q.a_y = ay; q.a_z = az;
      q.b_x = bx; q.b_y = by; q.b_z = bz;
      q.scale_factor = s;
      return q;
   endfunction

   function automatic response_type make_rsp(input logic signed [31:0] x, y, z, sc,
                                             input logic ov);
      response_type r;
      r.r_x = x; r.r_y = y; r.r_z = z; r.scalar_out = sc; r.overflow = ov;
      return r;
   endfunction

   // Values mostly small so that products stay in range, sometimes full width.
   function automatic logic signed [31:0] rand_fix();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? FIX_MAX - $urandom_range(0, 3)
                                        : FIX_MIN + $urandom_range(0, 3);
         2: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
         default: return 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
      endcase
   endfunction

   // The push stays high from one transfer to the next when no gap is drawn.
   task automatic send_request(input request_type q, input bit known,
                               input response_type rsp);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_q.push_back(known ? rsp : predict_vector_op(q));
   endtask

   // Sender.
   initial begin
      stim_row rows[$];
      request_type q;
      errors    = 0;
      stim_done = 1'b0;
      hold_rsp  = 1'b0;
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back('{make_req(OP_ADD, ONE, 2*ONE, -ONE, ONE, ONE, ONE, 0), 1,
                       make_rsp(2*ONE, 3*ONE, 0, 0, 0)});
      rows.push_back('{make_req(OP_ADD, FIX_MAX, FIX_MIN, 0, ONE, -ONE, 0, 0), 1,
                       make_rsp(FIX_MAX, FIX_MIN, 0, 0, 1)});
      rows.push_back('{make_req(OP_SUB, FIX_MIN, FIX_MAX, 5, ONE, -ONE, 5, 0), 1,
                       make_rsp(FIX_MIN, FIX_MAX, 0, 0, 1)});
      rows.push_back('{make_req(OP_NEGATE, FIX_MIN, FIX_MAX, ONE, 0, 0, 0, 0), 1,
                       make_rsp(FIX_MAX, FIX_MIN + 1, -ONE, 0, 1)});
      rows.push_back('{make_req(OP_SCALE, ONE, -ONE, 3, 0, 0, 0, 2*ONE), 1,
                       make_rsp(2*ONE, -2*ONE, 6, 0, 0)});
      rows.push_back('{make_req(OP_SCALE, FIX_MAX, FIX_MIN, -1, 0, 0, 0, FIX_MAX), 0, '0});
      rows.push_back('{make_req(OP_LENGTH, 3*ONE, 4*ONE, 0, 0, 0, 0, 0), 1,
                       make_rsp(0, 0, 0, 5*ONE, 0)});
      rows.push_back('{make_req(OP_LENGTH, 0, 0, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, 0)});
      rows.push_back('{make_req(OP_LENGTH, FIX_MIN, FIX_MIN, FIX_MIN, 0, 0, 0, 0), 1,
                       make_rsp(0, 0, 0, FIX_MAX, 1)});
      rows.push_back('{make_req(OP_NORMALIZE, 0, 0, 0, 1, 1, 1, 1), 1, make_rsp(0, 0, 0, 0, 0)});
      rows.push_back('{make_req(OP_NORMALIZE, 3*ONE, 0, -4*ONE, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(OP_NORMALIZE, FIX_MIN, FIX_MAX, 1, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(OP_NORMALIZE, 0, 0, 1, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(OP_DISTANCE, 4*ONE, 0, 0, ONE, -4*ONE, 0, 0), 1,
                       make_rsp(0, 0, 0, 5*ONE, 0)});
      rows.push_back('{make_req(OP_DISTANCE, FIX_MAX, 0, 0, FIX_MIN, 0, 0, 0), 1,
                       make_rsp(0, 0, 0, FIX_MAX, 1)});
      rows.push_back('{make_req(OP_DOT, ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 0), 1,
                       make_rsp(0, 0, 0, 32*ONE, 0)});
      rows.push_back('{make_req(OP_DOT, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
                                FIX_MIN, 0), 1, make_rsp(0, 0, 0, FIX_MAX, 1)});
      rows.push_back('{make_req(OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0), 1,
                       make_rsp(0, 0, ONE, 0, 0)});
      rows.push_back('{make_req(OP_CROSS, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX,
                                FIX_MIN, 0), 0, '0});
      rows.push_back('{make_req(4'd9, ONE, ONE, ONE, ONE, ONE, ONE, ONE), 1,
                       make_rsp(0, 0, 0, 0, 0)});
      rows.push_back('{make_req(4'd15, -1, -1, -1, -1, -1, -1, -1), 1,
                       make_rsp(0, 0, 0, 0, 0)});
      rows.push_back('{make_req(OP_SCALE, -1, -1, -1, 0, 0, 0, 1), 1,
                       make_rsp(-1, -1, -1, 0, 0)});
      foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].rsp);

      for (int n = 0; n < N_RANDOM; n++) begin
         // Mid-run the sender waits until the block has drained completely.
         if (n == 150) begin
            req_push <= 1'b0;
            while (expected_q.size() != 0) @(posedge clock);
         end
         if (n == 250) hold_rsp <= 1'b1;
         q = make_req($urandom_range(0, 19) == 0 ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8)),
                      rand_fix(), rand_fix(), rand_fix(),
                      rand_fix(), rand_fix(), rand_fix(), rand_fix());
         send_request(q, 1'b0, '0);
      end
      req_push  <= 1'b0;
      stim_done <= 1'b1;
   end

   // Receiver. While hold_rsp is set it holds off long enough for the block to
   // fill up and push back on the sender.
   initial begin
      int gap;
      rsp_pop = 1'b0;
      forever begin
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   // Checks each response transfer against the oldest expectation.
   always @(posedge clock) begin
      response_type exp_rsp;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_q.size() == 0) begin
            $error("response with nothing expected: %h", rsp_data);
            errors++;
         end else begin
            exp_rsp = expected_q.pop_front();
            if (rsp_data.r_x !== exp_rsp.r_x) begin
               $error("r_x expected %h actual %h", exp_rsp.r_x, rsp_data.r_x);
               errors++;
            end
            if (rsp_data.r_y !== exp_rsp.r_y) begin
               $error("r_y expected %h actual %h", exp_rsp.r_y, rsp_data.r_y);
               errors++;
            end
            if (rsp_data.r_z !== exp_rsp.r_z) begin
               $error("r_z expected %h actual %h", exp_rsp.r_z, rsp_data.r_z);
               errors++;
            end
            if (rsp_data.scalar_out !== exp_rsp.scalar_out) begin
               $error("scalar_out expected %h actual %h", exp_rsp.scalar_out,
                      rsp_data.scalar_out);
               errors++;
            end
            if (rsp_data.overflow !== exp_rsp.overflow) begin
               $error("overflow expected %b actual %b", exp_rsp.overflow,
                      rsp_data.overflow);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer, and the end of the run.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
         end
         if (stim_done && expected_q.size() == 0) begin
            repeat (LATENCY + 20) @(posedge clock);
            if (errors == 0 && expected_q.size() == 0) begin
               $display("TB_OK");
            end else begin
               $display("TB_ERROR");
            end
            $finish;
         end
      end
   end

endmodule

@@ files.f @@
hw/rtl/vau_pkg.sv
hw/rtl/vau_fifo.sv
hw/rtl/vau_front.sv
hw/rtl/vau_sqrt.sv
hw/rtl/vau_div.sv
hw/rtl/vau_back.sv
hw/rtl/vector3_arithmetic_unit.sv
bench/tb_vector3_arithmetic_unit.sv
